// File: sv/nlp_pkg.sv
// Shared types and constants for the next lexicographic permutation block.
// Used by nlp_pivot, nlp_permute, the top level and the checker.
`default_nettype none

package nlp_pkg;

  // Width of the length field and of a position index (up to 16 positions).
  localparam int LEN_W = 4;
  localparam int IDX_W = 4;

  // Rearrangement plan handed from the pivot search to the output select.
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] piv;
    logic [IDX_W-1:0] swp;
    logic [LEN_W-1:0] len;
  } nlp_sel_t;

endpackage

`default_nettype wire

// File: sv/nlp_pivot.sv
// Pivot and swap-partner search for the next lexicographic permutation.
// Depends on nlp_pkg for the index widths and the plan struct.
`default_nettype none

module nlp_pivot #(
  parameter int MAX_LEN    = 8,
  parameter int ELEM_WIDTH = 8
) (
  input  wire logic [MAX_LEN-1:0][ELEM_WIDTH-1:0] elems,
  input  wire logic [nlp_pkg::LEN_W-1:0]          length,
  output nlp_pkg::nlp_sel_t                       sel
);

  // Largest length that the field can carry and the sequence can hold.
  localparam logic [nlp_pkg::LEN_W-1:0] LEN_SAT =
    nlp_pkg::LEN_W'((MAX_LEN > 15) ? 15 : MAX_LEN);

  logic [nlp_pkg::LEN_W-1:0] len;
  logic                      found;
  logic [nlp_pkg::IDX_W-1:0] piv;
  logic [nlp_pkg::IDX_W-1:0] swp;
  logic [ELEM_WIDTH-1:0]     pv;

  always_comb begin
    len = (length > LEN_SAT) ? LEN_SAT : length;

    // Rightmost ascent inside the valid part; later matches win.
    found = 1'b0;
    piv   = '0;
    for (int k = 1; k < MAX_LEN; k++) begin
      if ((nlp_pkg::IDX_W'(k) < len) && (elems[k-1] < elems[k])) begin
        found = 1'b1;
        piv   = nlp_pkg::IDX_W'(k - 1);
      end
    end

    pv = '0;
    for (int k = 0; k < MAX_LEN; k++) begin
      if (nlp_pkg::IDX_W'(k) == piv) begin
        pv = elems[k];
      end
    end

    // Rightmost later element strictly above the pivot value.
    swp = piv + nlp_pkg::IDX_W'(1);
    for (int k = 0; k < MAX_LEN; k++) begin
      if ((nlp_pkg::IDX_W'(k) > piv) && (nlp_pkg::IDX_W'(k) < len) && (pv < elems[k])) begin
        swp = nlp_pkg::IDX_W'(k);
      end
    end

    sel.found = found;
    sel.piv   = piv;
    sel.swp   = swp;
    sel.len   = len;
  end

endmodule

`default_nettype wire

// File: sv/nlp_permute.sv
// Output select: applies the swap and the suffix reversal in one mux per position.
// Depends on nlp_pkg for the plan struct produced by nlp_pivot.
`default_nettype none

module nlp_permute #(
  parameter int MAX_LEN    = 8,
  parameter int ELEM_WIDTH = 8
) (
  input  wire logic [MAX_LEN-1:0][ELEM_WIDTH-1:0] elems,
  input  wire nlp_pkg::nlp_sel_t                  sel,
  output logic [MAX_LEN-1:0][ELEM_WIDTH-1:0]      outs,
  output logic                                    no_next
);

  localparam int CW = nlp_pkg::IDX_W + 1;

  logic [nlp_pkg::IDX_W-1:0] src [MAX_LEN];
  logic [CW-1:0]             jv  [MAX_LEN];

  always_comb begin
    for (int i = 0; i < MAX_LEN; i++) begin
      src[i] = nlp_pkg::IDX_W'(i);
      // Mirror position inside the reversed suffix.
      jv[i]  = CW'(sel.len) + CW'(sel.piv) - CW'(i);
      if (sel.found) begin
        if (nlp_pkg::IDX_W'(i) == sel.piv) begin
          src[i] = sel.swp;
        end else if ((nlp_pkg::IDX_W'(i) > sel.piv) && (nlp_pkg::IDX_W'(i) < sel.len)) begin
          // The swap partner's slot holds the old pivot value before reversal.
          src[i] = (jv[i][nlp_pkg::IDX_W-1:0] == sel.swp) ? sel.piv
                                                           : jv[i][nlp_pkg::IDX_W-1:0];
        end
      end
      outs[i] = '0;
      for (int k = 0; k < MAX_LEN; k++) begin
        if (nlp_pkg::IDX_W'(k) == src[i]) begin
          outs[i] = elems[k];
        end
      end
    end
    no_next = !sel.found;
  end

endmodule

`default_nettype wire

// File: sv/next_lex_permutation_top.sv
// Top level of the next lexicographic permutation block: input register,
// pivot search, output select and result register. Uses nlp_pkg, nlp_pivot, nlp_permute.
//
//  channel  | direction | tdata (low bit up)               | tuser
//  ---------+-----------+----------------------------------+---------
//  s_ (in)  | slave     | elem_0 .. elem_N-1, length, pad  | none
//  m_ (out) | master    | out_0 .. out_N-1, pad            | no_next
//
// Each accepted word is held in the input register, then passes through the pivot
// search and select into the result register.
// A new word is taken every cycle while the result side keeps up.
// A stall on m_tready holds the result register; the input register still fills
// while it is empty, so s_tready drops only when both stages are occupied.
// Reset clears both valid flags; payload registers are not reset.
`default_nettype none

module next_lex_permutation_top #(
  parameter int MAX_LEN    = 8,
  parameter int ELEM_WIDTH = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  // elem_0 .. elem_{MAX_LEN-1}, length, zero pad
  input  wire logic [((MAX_LEN*ELEM_WIDTH+nlp_pkg::LEN_W+7)/8)*8-1:0] s_tdata,
  output logic      m_tvalid,
  input  wire logic m_tready,
  // out_0 .. out_{MAX_LEN-1}, zero pad
  output logic [((MAX_LEN*ELEM_WIDTH+7)/8)*8-1:0] m_tdata,
  // no_next
  output logic [0:0] m_tuser
);

  localparam int SEQ_W     = MAX_LEN * ELEM_WIDTH;
  localparam int OUT_TDATA = ((SEQ_W + 7) / 8) * 8;

  logic                                   v1;
  logic [MAX_LEN-1:0][ELEM_WIDTH-1:0]     elems;
  logic [nlp_pkg::LEN_W-1:0]              length;
  logic                                   v2;
  logic [MAX_LEN-1:0][ELEM_WIDTH-1:0]     res;
  logic                                   res_no_next;

  logic                                   adv1;
  logic                                   adv2;
  nlp_pkg::nlp_sel_t                      sel;
  logic [MAX_LEN-1:0][ELEM_WIDTH-1:0]     outs;
  logic                                   no_next;

  assign adv2     = !v2 || m_tready;
  assign adv1     = !v1 || adv2;
  assign s_tready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= s_tvalid;
      end
      if (adv2) begin
        v2 <= v1;
      end
    end
    if (adv1 && s_tvalid) begin
      elems  <= s_tdata[SEQ_W-1:0];
      length <= s_tdata[SEQ_W +: nlp_pkg::LEN_W];
    end
    if (adv2 && v1) begin
      res         <= outs;
      res_no_next <= no_next;
    end
  end

  nlp_pivot #(
    .MAX_LEN    (MAX_LEN),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_pivot (
    .elems  (elems),
    .length (length),
    .sel    (sel)
  );

  nlp_permute #(
    .MAX_LEN    (MAX_LEN),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_permute (
    .elems   (elems),
    .sel     (sel),
    .outs    (outs),
    .no_next (no_next)
  );

  assign m_tvalid   = v2;
  assign m_tdata    = OUT_TDATA'(res);
  assign m_tuser[0] = res_no_next;

endmodule

`default_nettype wire

// File: sv/nlp_checker.sv
// Port-level checker for next_lex_permutation_top, attached by the bind below.
// Depends on nlp_pkg for the length field width.
`default_nettype none

module nlp_checker #(
  parameter int MAX_LEN    = 8,
  parameter int ELEM_WIDTH = 8
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_tvalid,
  input wire logic s_tready,
  input wire logic [((MAX_LEN*ELEM_WIDTH+nlp_pkg::LEN_W+7)/8)*8-1:0] s_tdata,
  input wire logic m_tvalid,
  input wire logic m_tready,
  input wire logic [((MAX_LEN*ELEM_WIDTH+7)/8)*8-1:0] m_tdata,
  input wire logic [0:0] m_tuser
);

  localparam int SEQ_W = MAX_LEN * ELEM_WIDTH;

  // A held result keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // With the output side free, an accepted word reaches the output.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) ##1 m_tready |=> m_tvalid)
    else $error("result missing two cycles after acceptance");

  // A sequence shorter than two has no successor and passes through unchanged.
  a_short: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tdata[SEQ_W +: nlp_pkg::LEN_W] < nlp_pkg::LEN_W'(2)))
      ##1 m_tready
      |=> m_tuser[0] && (m_tdata[SEQ_W-1:0] == $past(s_tdata[SEQ_W-1:0], 2)))
    else $error("short sequence was altered or not flagged");

endmodule

bind next_lex_permutation_top nlp_checker #(
  .MAX_LEN    (MAX_LEN),
  .ELEM_WIDTH (ELEM_WIDTH)
) u_nlp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
